// ===== src/spns_pkg.sv =====
// shared types and codes of the snap point nearest search block
`default_nettype none

package spns_pkg;

    localparam logic [1:0] OP_INSERT     = 2'd0;
    localparam logic [1:0] OP_REMOVE     = 2'd1;
    localparam logic [1:0] OP_CLEAR_GRID = 2'd2;
    localparam logic [1:0] OP_QUERY      = 2'd3;

    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_CENTER = 2'd1;
    localparam logic [1:0] KIND_INTER  = 2'd2;
    localparam logic [1:0] KIND_GRID   = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_POINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_INTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_GRID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SHOW = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         point_kind;
        logic [15:0]        owner_first;
        logic [15:0]        owner_second;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [31:0]        capture_radius;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic signed [31:0] snap_x;
        logic signed [31:0] snap_y;
        logic [1:0]         snap_kind;
        logic               table_full;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic commit;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/snap_point_nearest_search.sv =====
// snap point table with nearest match search inside a capture radius
//
// input channel i_in_valid / o_in_ready carries one word per operation:
// insert, remove by owner, clear grid entries or query. output channel
// o_out_valid / i_out_ready returns exactly one word per input word.
// one operation is worked at a time; o_in_ready is high while idle.
// insert: the entry is written at acceptance and the result state follows with no table walk.
// remove, clear and query: the table is walked once, one entry per cycle
// through the single read port, then a 4 stage distance pipeline drains.
// the output register holds a finished word while the receiver stalls;
// the next input word is taken as soon as the result is queued, and a
// later result waits in its last state until the register frees up.
// config writes on i_cfg_we take effect at once and must come while idle.
// reset (i_rst_n low, synchronous) empties the table, restores the
// enable registers and drops any pending output word.
`default_nettype none

module snap_point_nearest_search
    import spns_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                 i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    spns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_in_word.opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    spns_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== src/spns_ctrl.sv =====
// controller state machine sequencing insert, scan, drain and result
`default_nettype none

module spns_ctrl
    import spns_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_opcode,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_ctrl_cmd       o_cmd,
    input  wire t_dp_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_opcode == OP_INSERT) ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== src/spns_dpath.sv =====
// datapath: entry table, compaction pointers, distance pipeline and best tracker
`default_nettype none

module spns_dpath
    import spns_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                 i_cfg_data,
    input  wire t_in_word             i_in_word,
    input  wire t_ctrl_cmd            i_cmd,
    output t_dp_status                o_status,
    output t_out_word                 o_out_word
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] owner_first;
        logic [15:0] owner_second;
        logic [31:0] x;
        logic [31:0] y;
    } t_entry;

    // config
    logic r_en_point;
    logic r_en_center;
    logic r_en_inter;
    logic r_en_grid;
    logic r_grid_shown;
    logic [3:0] en_mask;

    // latched word
    logic [1:0]  r_op;
    logic [15:0] r_owner;
    logic [31:0] r_qx;
    logic [31:0] r_qy;
    logic [31:0] r_rad;
    logic        r_full;

    // table
    t_entry        mem [TABLE_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_ptr;
    logic [CW-1:0] r_wr_ptr;
    t_entry        r_rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          ins_ok;
    logic          compact;
    logic          drop;
    logic          keep_wr;

    // capture limit
    logic [63:0] r_rad_sq;
    logic [65:0] r_lim2;

    // distance pipeline
    logic        r_p1_valid;
    logic        r_p2_valid;
    logic [1:0]  r_p2_kind;
    logic [31:0] r_p2_x;
    logic [31:0] r_p2_y;
    logic [31:0] r_p2_dx;
    logic [31:0] r_p2_dy;
    logic        r_p3_valid;
    logic [1:0]  r_p3_kind;
    logic [31:0] r_p3_x;
    logic [31:0] r_p3_y;
    logic [63:0] r_p3_sx;
    logic [63:0] r_p3_sy;
    logic        r_p4_valid;
    logic [1:0]  r_p4_kind;
    logic [31:0] r_p4_x;
    logic [31:0] r_p4_y;
    logic [64:0] r_p4_dist;
    logic [32:0] diff_x;
    logic [32:0] diff_y;
    logic [32:0] abs_x;
    logic [32:0] abs_y;
    logic        p2_take;

    // best so far
    logic        r_hit;
    logic [64:0] r_best_dist;
    logic [1:0]  r_best_kind;
    logic [31:0] r_best_x;
    logic [31:0] r_best_y;
    logic        better;

    t_out_word r_out_word;

    assign en_mask = {r_en_grid & r_grid_shown, r_en_inter, r_en_center, r_en_point};

    // table write port: insert at accept, compaction while scanning
    assign ins_ok  = i_cmd.accept && (i_in_word.opcode == OP_INSERT) && (r_count != DEPTH_C);
    assign compact = (r_op == OP_REMOVE) || (r_op == OP_CLEAR_GRID);

    always_comb begin
        if (r_op == OP_CLEAR_GRID) begin
            drop = (r_rd_data.kind == KIND_GRID);
        end else begin
            drop = (r_rd_data.kind != KIND_GRID) &&
                   ((r_rd_data.owner_first == r_owner) ||
                    ((r_rd_data.kind == KIND_INTER) && (r_rd_data.owner_second == r_owner)));
        end
    end

    assign keep_wr = r_p1_valid && compact && !drop;
    assign wr_en   = ins_ok || keep_wr;

    always_comb begin
        if (ins_ok) begin
            wr_addr              = r_count[AW-1:0];
            wr_data.kind         = i_in_word.point_kind;
            wr_data.owner_first  = i_in_word.owner_first;
            wr_data.owner_second = (i_in_word.point_kind == KIND_INTER) ?
                                   i_in_word.owner_second : 16'd0;
            wr_data.x            = i_in_word.coord_x;
            wr_data.y            = i_in_word.coord_y;
        end else begin
            wr_addr = r_wr_ptr[AW-1:0];
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_rd_ptr[AW-1:0]];
    end

    // distance stages
    assign diff_x  = {r_qx[31], r_qx} - {r_rd_data.x[31], r_rd_data.x};
    assign diff_y  = {r_qy[31], r_qy} - {r_rd_data.y[31], r_rd_data.y};
    assign abs_x   = diff_x[32] ? (~diff_x + 33'd1) : diff_x;
    assign abs_y   = diff_y[32] ? (~diff_y + 33'd1) : diff_y;
    assign p2_take = r_p1_valid && (r_op == OP_QUERY) && en_mask[r_rd_data.kind];

    assign better = r_p4_valid && ({1'b0, r_p4_dist} < r_lim2) &&
                    (!r_hit || (r_p4_dist < r_best_dist) ||
                     ((r_p4_dist == r_best_dist) && (r_p4_kind < r_best_kind)));

    always_ff @(posedge i_clk) begin
        r_rad_sq  <= r_rad * r_rad;
        r_lim2    <= 66'(r_rad_sq) + (66'(r_rad) << 17) + (66'd1 << 32);

        r_p2_kind <= r_rd_data.kind;
        r_p2_x    <= r_rd_data.x;
        r_p2_y    <= r_rd_data.y;
        r_p2_dx   <= abs_x[31:0];
        r_p2_dy   <= abs_y[31:0];

        r_p3_kind <= r_p2_kind;
        r_p3_x    <= r_p2_x;
        r_p3_y    <= r_p2_y;
        r_p3_sx   <= r_p2_dx * r_p2_dx;
        r_p3_sy   <= r_p2_dy * r_p2_dy;

        r_p4_kind <= r_p3_kind;
        r_p4_x    <= r_p3_x;
        r_p4_y    <= r_p3_y;
        r_p4_dist <= 65'(r_p3_sx) + 65'(r_p3_sy);

        if (better) begin
            r_best_dist <= r_p4_dist;
            r_best_kind <= r_p4_kind;
            r_best_x    <= r_p4_x;
            r_best_y    <= r_p4_y;
        end

        if (i_cmd.accept) begin
            r_op    <= i_in_word.opcode;
            r_owner <= i_in_word.owner_first;
            r_qx    <= i_in_word.coord_x;
            r_qy    <= i_in_word.coord_y;
            r_rad   <= i_in_word.capture_radius;
            r_full  <= (r_count == DEPTH_C);
        end

        if (i_cmd.load_out) begin
            r_out_word.found      <= (r_op == OP_QUERY) && r_hit;
            r_out_word.snap_x     <= ((r_op == OP_QUERY) && r_hit) ? r_best_x : 32'd0;
            r_out_word.snap_y     <= ((r_op == OP_QUERY) && r_hit) ? r_best_y : 32'd0;
            r_out_word.snap_kind  <= ((r_op == OP_QUERY) && r_hit && (r_best_kind != KIND_GRID)) ?
                                     r_best_kind : KIND_POINT;
            r_out_word.table_full <= (r_op == OP_INSERT) && r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_point   <= 1'b1;
            r_en_center  <= 1'b1;
            r_en_inter   <= 1'b1;
            r_en_grid    <= 1'b0;
            r_grid_shown <= 1'b1;
            r_count      <= '0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_p1_valid   <= 1'b0;
            r_p2_valid   <= 1'b0;
            r_p3_valid   <= 1'b0;
            r_p4_valid   <= 1'b0;
            r_hit        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_EN_POINT:  r_en_point   <= i_cfg_data;
                    CFG_EN_CENTER: r_en_center  <= i_cfg_data;
                    CFG_EN_INTER:  r_en_inter   <= i_cfg_data;
                    CFG_EN_GRID:   r_en_grid    <= i_cfg_data;
                    CFG_GRID_SHOW: r_grid_shown <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            r_p1_valid <= i_cmd.rd_issue;
            r_p2_valid <= p2_take;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;

            if (i_cmd.accept) begin
                r_rd_ptr <= '0;
                r_wr_ptr <= '0;
                r_hit    <= 1'b0;
                if (ins_ok) begin
                    r_count <= r_count + CW'(1);
                end
            end else begin
                if (i_cmd.rd_issue) begin
                    r_rd_ptr <= r_rd_ptr + CW'(1);
                end
                if (keep_wr) begin
                    r_wr_ptr <= r_wr_ptr + CW'(1);
                end
                if (better) begin
                    r_hit <= 1'b1;
                end
                if (i_cmd.commit && compact) begin
                    r_count <= r_wr_ptr;
                end
            end
        end
    end

    assign o_status.scan_done = (r_rd_ptr == r_count);
    assign o_status.pipe_busy = r_p1_valid | r_p2_valid | r_p3_valid | r_p4_valid;
    assign o_out_word         = r_out_word;

`ifndef SYNTHESIS
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr <= r_rd_ptr)
        else $error("compaction write pointer passed read pointer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_count_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> $stable(r_count))
        else $error("entry count moved during a scan");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> ({1'b0, r_best_dist} < r_lim2))
        else $error("best match outside capture radius");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for snap_point_nearest_search with a built-in snap table predictor
`timescale 1ns / 100ps

module tb;
    import spns_pkg::*;

    localparam int DEPTH      = 256;
    localparam int RUN_LIMIT  = 2000000;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE     = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_word             i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data = 1'b0;

    snap_point_nearest_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow snap table and enables
    logic [1:0]         tbl_kind [DEPTH];
    logic [15:0]        tbl_own1 [DEPTH];
    logic [15:0]        tbl_own2 [DEPTH];
    logic signed [31:0] tbl_x    [DEPTH];
    logic signed [31:0] tbl_y    [DEPTH];
    int                 tbl_count = 0;
    bit en_point = 1'b1, en_center = 1'b1, en_inter = 1'b1, en_grid = 1'b0, grid_on = 1'b1;

    t_in_word  op_queue[$];
    t_out_word predicted_results[$];
    bit        in_offer = 1'b0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        steady = 1'b0;
    int        hold_requests = 0;
    int        holds_done = 0;
    int        mismatches = 0;
    int        cycles = 0;
    t_out_word want;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_out_word snap_lookup(t_in_word w);
        t_out_word   r;
        int          wr;
        int          rd;
        int          pass;
        bit          en;
        bit          drop;
        longint      dxl;
        longint      dyl;
        logic [67:0] ax;
        logic [67:0] ay;
        logic [67:0] d2;
        logic [67:0] lim;
        logic [67:0] best;
        r = '0;
        case (w.opcode)
            OP_INSERT: begin
                if (tbl_count >= DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    tbl_kind[tbl_count] = w.point_kind;
                    tbl_own1[tbl_count] = w.owner_first;
                    tbl_own2[tbl_count] = (w.point_kind == KIND_INTER) ? w.owner_second : 16'd0;
                    tbl_x[tbl_count]    = w.coord_x;
                    tbl_y[tbl_count]    = w.coord_y;
                    tbl_count++;
                end
            end
            OP_REMOVE, OP_CLEAR_GRID: begin
                wr = 0;
                for (rd = 0; rd < tbl_count; rd++) begin
                    if (w.opcode == OP_CLEAR_GRID)
                        drop = (tbl_kind[rd] == KIND_GRID);
                    else
                        drop = (tbl_kind[rd] != KIND_GRID) &&
                               (tbl_own1[rd] == w.owner_first ||
                                (tbl_kind[rd] == KIND_INTER && tbl_own2[rd] == w.owner_first));
                    if (!drop) begin
                        tbl_kind[wr] = tbl_kind[rd];
                        tbl_own1[wr] = tbl_own1[rd];
                        tbl_own2[wr] = tbl_own2[rd];
                        tbl_x[wr]    = tbl_x[rd];
                        tbl_y[wr]    = tbl_y[rd];
                        wr++;
                    end
                end
                tbl_count = wr;
            end
            default: begin
                lim  = 68'(w.capture_radius) + 68'd65536;
                best = lim * lim;
                for (pass = 0; pass < 4; pass++) begin
                    case (pass[1:0])
                        KIND_POINT:  en = en_point;
                        KIND_CENTER: en = en_center;
                        KIND_INTER:  en = en_inter;
                        default:     en = en_grid && grid_on;
                    endcase
                    if (en) begin
                        for (rd = 0; rd < tbl_count; rd++) begin
                            if (tbl_kind[rd] == pass[1:0]) begin
                                dxl = longint'($signed(w.coord_x)) - longint'(tbl_x[rd]);
                                dyl = longint'($signed(w.coord_y)) - longint'(tbl_y[rd]);
                                if (dxl < 0) dxl = -dxl;
                                if (dyl < 0) dyl = -dyl;
                                ax = 68'(dxl);
                                ay = 68'(dyl);
                                d2 = ax * ax + ay * ay;
                                if (d2 < best) begin
                                    best        = d2;
                                    r.found     = 1'b1;
                                    r.snap_x    = tbl_x[rd];
                                    r.snap_y    = tbl_y[rd];
                                    r.snap_kind = (pass[1:0] == KIND_GRID) ? KIND_POINT : pass[1:0];
                                end
                            end
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic int draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $error("%s: expected %h, got %h", name, want_v, got_v);
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_offer = 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_results.insert(predicted_results.size(), snap_lookup(i_in_word));
                in_offer = 1'b0;
            end
            if (!in_offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (op_queue.size() != 0) begin
                    i_in_word <= op_queue.pop_front();
                    in_offer = 1'b1;
                    send_gap = steady ? 0 : draw_gap();
                end
            end
            i_in_valid <= in_offer;
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    $error("result word with no operation pending");
                end else begin
                    want = predicted_results.pop_front();
                    report_field("found", 32'(want.found), 32'(o_out_word.found));
                    report_field("snap_x", want.snap_x, o_out_word.snap_x);
                    report_field("snap_y", want.snap_y, o_out_word.snap_y);
                    report_field("snap_kind", 32'(want.snap_kind), 32'(o_out_word.snap_kind));
                    report_field("table_full", 32'(want.table_full), 32'(o_out_word.table_full));
                end
            end
            if (holds_done < hold_requests) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                stall_left = draw_gap();
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    function automatic t_in_word make_word(logic [1:0] op, logic [1:0] kind, logic [15:0] o1,
                                           logic [15:0] o2, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] rad);
        t_in_word w;
        w.opcode         = op;
        w.point_kind     = kind;
        w.owner_first    = o1;
        w.owner_second   = o2;
        w.coord_x        = x;
        w.coord_y        = y;
        w.capture_radius = rad;
        return w;
    endfunction

    task automatic queue_op(t_in_word w);
        op_queue.insert(op_queue.size(), w);
    endtask

    function automatic logic [31:0] pick_coord();
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            v = int'($urandom_range(0, 8)) - 4;
            return v * 65536;
        end
        if (sel < 80) begin
            v = int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
            return v;
        end
        if (sel < 92) return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_radius();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return $urandom_range(0, 3 * 65536);
        if (sel < 80) return $urandom_range(0, 65535);
        if (sel < 92) return $urandom();
        return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [15:0] pick_owner();
        if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 7));
        return 16'($urandom());
    endfunction

    task automatic add_random(int count, int pct_ins, int pct_rem, int pct_clr);
        t_in_word    w;
        int unsigned roll;
        int          n;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < pct_ins)
                w.opcode = OP_INSERT;
            else if (roll < pct_ins + pct_rem)
                w.opcode = OP_REMOVE;
            else if (roll < pct_ins + pct_rem + pct_clr)
                w.opcode = OP_CLEAR_GRID;
            else
                w.opcode = OP_QUERY;
            w.point_kind     = 2'($urandom_range(0, 3));
            w.owner_first    = pick_owner();
            w.owner_second   = pick_owner();
            w.coord_x        = pick_coord();
            w.coord_y        = pick_coord();
            w.capture_radius = pick_radius();
            queue_op(w);
        end
    endtask

    task automatic drain();
        while (op_queue.size() != 0 || in_offer || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, bit val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_EN_POINT:  en_point  = val;
            CFG_EN_CENTER: en_center = val;
            CFG_EN_INTER:  en_inter  = val;
            CFG_EN_GRID:   en_grid   = val;
            CFG_GRID_SHOW: grid_on   = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(bit p, bit c, bit n, bit g, bit s);
        drain();
        set_reg(CFG_EN_POINT, p);
        set_reg(CFG_EN_CENTER, c);
        set_reg(CFG_EN_INTER, n);
        set_reg(CFG_EN_GRID, g);
        set_reg(CFG_GRID_SHOW, s);
        repeat (2) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed checks with reset enables
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 0, 0, 32'hFFFF_FFFF));
        queue_op(make_word(OP_INSERT, KIND_POINT, 1, 7, 0, 0, 0));
        queue_op(make_word(OP_INSERT, KIND_CENTER, 2, 0, 32'h0001_0000, 0, 0));
        queue_op(make_word(OP_INSERT, KIND_INTER, 3, 16'hFFFF, 0, 32'h0001_0000, 0));
        queue_op(make_word(OP_INSERT, KIND_GRID, 16'hFFFF, 16'hFFFF,
                           32'h7FFF_FFFF, 32'h8000_0000, 0));
        queue_op(make_word(OP_INSERT, KIND_POINT, 16'hFFFF, 16'hFFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 0, 0, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 32'h0000_8000, 0, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 32'h0000_8000, 32'h0000_8000, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'hFFFF_FFFF));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 32'h0001_0000, 0, 0));
        queue_op(make_word(OP_REMOVE, KIND_POINT, 16'hFFFF, 0, 0, 0, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'hFFFF_FFFF));
        queue_op(make_word(OP_CLEAR_GRID, KIND_POINT, 0, 0, 0, 0, 0));
        queue_op(make_word(OP_REMOVE, KIND_POINT, 1, 0, 0, 0, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 0, 0, 32'h0001_8000));
        queue_op(make_word(OP_INSERT, KIND_INTER, 5, 0, 32'hFFFF_8000, 0, 0));
        queue_op(make_word(OP_REMOVE, KIND_POINT, 0, 0, 0, 0, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 0, 32'h0000_8000, 0));
        queue_op(make_word(OP_REMOVE, KIND_POINT, 2, 0, 0, 0, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 0, 0, 32'hFFFF_FFFF));

        // everything enabled, grid match reported as point
        apply_setting(1, 1, 1, 1, 1);
        queue_op(make_word(OP_INSERT, KIND_GRID, 0, 0, 0, 0, 0));
        queue_op(make_word(OP_INSERT, KIND_POINT, 4, 0, 32'h0001_0000, 0, 0));
        queue_op(make_word(OP_QUERY, KIND_POINT, 0, 0, 0, 0, 0));
        add_random(180, 50, 8, 4);

        // all searches off while the table fills past full
        apply_setting(0, 0, 0, 0, 0);
        add_random(300, 95, 0, 0);

        // removal heavy with a long receiver hold at the start
        apply_setting(0, 1, 0, 1, 1);
        add_random(150, 30, 30, 5);
        hold_requests++;

        // grid enabled but hidden, no idling on either side
        apply_setting(1, 0, 1, 1, 0);
        steady = 1'b1;
        add_random(150, 45, 10, 5);

        drain();
        steady = 1'b0;
        apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        add_random(150, 45, 10, 5);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
